// ----- design/pac_pkg.sv -----
// shared constants for the pid anti-windup controller
// no dependencies

package pac_pkg;

    localparam int DEF_WORD_BITS = 32;
    localparam int DEF_FRAC_BITS = 16;

    // configuration register indexes
    localparam logic [2:0] REG_KP      = 3'd0;
    localparam logic [2:0] REG_TI      = 3'd1;
    localparam logic [2:0] REG_TD      = 3'd2;
    localparam logic [2:0] REG_TRIM    = 3'd3;
    localparam logic [2:0] REG_OUT_MIN = 3'd4;
    localparam logic [2:0] REG_OUT_MAX = 3'd5;
    localparam logic [2:0] REG_WRAP    = 3'd6;

    // error wrap modes
    localparam logic [1:0] WRAP_NONE = 2'd0;
    localparam logic [1:0] WRAP_DEG  = 2'd1;
    localparam logic [1:0] WRAP_RAD  = 2'd2;

    // handshake between the sequencer and an arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } pac_unit_status_t;

endpackage

// ----- design/pac_mul.sv -----
// bit-serial fixed point multiplier: shift-add, round to nearest, saturate
// depends on pac_pkg

module pac_mul
    import pac_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic signed [WORD_BITS-1:0] op_a,
    input  logic signed [WORD_BITS-1:0] op_b,
    output pac_unit_status_t            status,
    output logic signed [WORD_BITS-1:0] result
);

    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(W);
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_RUN  = 2'd1;
    localparam logic [1:0] PH_RND  = 2'd2;
    localparam logic [1:0] PH_SAT  = 2'd3;
    localparam logic [2*W-1:0] RND_HALF = (2*W)'(1) << (FRAC_BITS - 1);
    localparam logic [2*W-1:0] LIM      = (2*W)'(1) << (W - 1);

    logic [1:0]        phase_reg, phase_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [W-1:0]      mcand_reg, mcand_next;
    logic [2*W:0]      prod_reg, prod_next;
    logic [2*W-1:0]    rnd_reg, rnd_next;
    logic              neg_reg, neg_next;
    logic              done_reg, done_next;
    logic signed [W-1:0] result_reg, result_next;
    logic [W:0]        sum;
    logic [W-1:0]      mag_a, mag_b;

    assign mag_a = op_a[W-1] ? (~op_a + 1'b1) : op_a;
    assign mag_b = op_b[W-1] ? (~op_b + 1'b1) : op_b;
    assign sum = prod_reg[2*W:W] + (prod_reg[0] ? {1'b0, mcand_reg} : '0);

    always_comb begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        prod_next   = prod_reg;
        rnd_next    = rnd_reg;
        neg_next    = neg_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        unique case (phase_reg)
            PH_IDLE: begin
                if (start) begin
                    mcand_next = mag_a;
                    prod_next  = {(W+1)'(0), mag_b};
                    neg_next   = op_a[W-1] ^ op_b[W-1];
                    cnt_next   = '0;
                    phase_next = PH_RUN;
                end
            end
            PH_RUN: begin
                prod_next = {sum, prod_reg[W-1:0]} >> 1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1)) begin
                    phase_next = PH_RND;
                end
            end
            PH_RND: begin
                rnd_next   = (prod_reg[2*W-1:0] + RND_HALF) >> FRAC_BITS;
                phase_next = PH_SAT;
            end
            PH_SAT: begin
                if (neg_reg) begin
                    result_next = (rnd_reg > LIM) ? {1'b1, {(W-1){1'b0}}}
                                                  : W'(~rnd_reg + 1'b1);
                end else begin
                    result_next = (rnd_reg > LIM - 1'b1) ? {1'b0, {(W-1){1'b1}}}
                                                         : rnd_reg[W-1:0];
                end
                done_next  = 1'b1;
                phase_next = PH_IDLE;
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
        cnt_reg    <= cnt_next;
        mcand_reg  <= mcand_next;
        prod_reg   <= prod_next;
        rnd_reg    <= rnd_next;
        neg_reg    <= neg_next;
        result_reg <= result_next;
    end

    assign status.busy = (phase_reg != PH_IDLE);
    assign status.done = done_reg;
    assign result      = result_reg;

endmodule

// ----- design/pac_div.sv -----
// bit-serial fixed point divider: restoring, one quotient bit a cycle,
// rounded to nearest and saturated; depends on pac_pkg

module pac_div
    import pac_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic signed [WORD_BITS-1:0] op_a,
    input  logic signed [WORD_BITS-1:0] op_b,
    output pac_unit_status_t            status,
    output logic signed [WORD_BITS-1:0] result
);

    localparam int W  = WORD_BITS;
    localparam int N  = WORD_BITS + FRAC_BITS + 1;
    localparam int CW = $clog2(N + 1);
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_PREP = 2'd1;
    localparam logic [1:0] PH_RUN  = 2'd2;
    localparam logic [1:0] PH_SAT  = 2'd3;
    localparam logic [N-1:0] LIM = N'(1) << (W - 1);

    logic [1:0]     phase_reg, phase_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [W-1:0]   ua_reg, ua_next, ub_reg, ub_next;
    logic [N-1:0]   num_reg, num_next;
    logic [W-1:0]   rem_reg, rem_next;
    logic           neg_reg, neg_next, nega_reg, nega_next;
    logic           done_reg, done_next;
    logic signed [W-1:0] result_reg, result_next;
    logic [W:0]     shifted, diff;
    logic           fits;

    assign shifted = {rem_reg, num_reg[N-1]};
    assign diff    = shifted - {1'b0, ub_reg};
    assign fits    = (shifted >= {1'b0, ub_reg});

    always_comb begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        ua_next     = ua_reg;
        ub_next     = ub_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        neg_next    = neg_reg;
        nega_next   = nega_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        unique case (phase_reg)
            PH_IDLE: begin
                if (start) begin
                    ua_next    = op_a[W-1] ? (~op_a + 1'b1) : op_a;
                    ub_next    = op_b[W-1] ? (~op_b + 1'b1) : op_b;
                    neg_next   = op_a[W-1] ^ op_b[W-1];
                    nega_next  = op_a[W-1];
                    phase_next = PH_PREP;
                end
            end
            PH_PREP: begin
                num_next = ({1'b0, ua_reg, {FRAC_BITS{1'b0}}}) + N'(ub_reg >> 1);
                rem_next = '0;
                cnt_next = '0;
                phase_next = (ub_reg == '0) ? PH_SAT : PH_RUN;
            end
            PH_RUN: begin
                rem_next = fits ? diff[W-1:0] : shifted[W-1:0];
                num_next = {num_reg[N-2:0], fits};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(N - 1)) begin
                    phase_next = PH_SAT;
                end
            end
            PH_SAT: begin
                if (ub_reg == '0) begin
                    // divide by zero: zero stays zero, else full scale by sign
                    if (ua_reg == '0) begin
                        result_next = '0;
                    end else begin
                        result_next = nega_reg ? {1'b1, {(W-1){1'b0}}}
                                               : {1'b0, {(W-1){1'b1}}};
                    end
                end else if (neg_reg) begin
                    result_next = (num_reg > LIM) ? {1'b1, {(W-1){1'b0}}}
                                                  : W'(~num_reg + 1'b1);
                end else begin
                    result_next = (num_reg > LIM - 1'b1) ? {1'b0, {(W-1){1'b1}}}
                                                         : num_reg[W-1:0];
                end
                done_next  = 1'b1;
                phase_next = PH_IDLE;
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
        cnt_reg    <= cnt_next;
        ua_reg     <= ua_next;
        ub_reg     <= ub_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        nega_reg   <= nega_next;
        result_reg <= result_next;
    end

    assign status.busy = (phase_reg != PH_IDLE);
    assign status.done = done_reg;
    assign result      = result_reg;

endmodule

// ----- design/pid_antiwindup_controller.sv -----
// pid controller with bumpless reset and back-calculation anti-windup; needs pac_pkg, pac_mul, pac_div
// sequence: error, wrap, proportional multiply, then integral gain divide and two multiplies, bumpless
//   reset, derivative difference, two multiplies and a divide, two sums, two clamps, hand-over; integral
//   steps skipped with the integral off, derivative divide skipped when time_step is zero; default Q16.16
// throughput: one word at a time; the next input word is taken while a result waits
// reset: synchronous active-low aresetn clears integral and last measurement, sets reset pending

module pid_antiwindup_controller
    import pac_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_addr,
    input  logic [WORD_BITS-1:0]   cfg_wdata,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // measurement, setpoint, present_drive, time_step, zero pad
    input  logic [((4*WORD_BITS-1+7)/8)*8-1:0] s_tdata,
    // enable, reset_request
    input  logic [1:0]             s_tuser,
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // drive, integral_term, zero pad
    output logic [((2*WORD_BITS+7)/8)*8-1:0]   m_tdata,
    // drive_written
    output logic [0:0]             m_tuser
);

    localparam int W      = WORD_BITS;
    localparam int OUT_TW = ((2*WORD_BITS+7)/8)*8;
    // wide enough for sums of two words and for the wrap constants
    localparam int XW     = ((W > FRAC_BITS + 10) ? W : FRAC_BITS + 10) + 2;

    localparam logic signed [XW-1:0] WMAX_X   = (XW'(1) <<< (W - 1)) - 1;
    localparam logic signed [XW-1:0] WMIN_X   = -WMAX_X - 1;
    localparam logic signed [XW-1:0] HALF_DEG = XW'(180) <<< FRAC_BITS;
    localparam logic signed [XW-1:0] FULL_DEG = XW'(360) <<< FRAC_BITS;
    localparam logic [63:0]          PI_Q32   = 64'd13493037705;
    localparam logic [63:0]          PI_F     = (FRAC_BITS >= 32) ? PI_Q32 :
        ((PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
    localparam logic signed [XW-1:0] PI_X     = XW'(PI_F);
    localparam logic signed [XW-1:0] TWO_PI_X = PI_X <<< 1;
    localparam logic [63:0]          THR_64   = (64'd1 << FRAC_BITS) / 10000;
    localparam logic [W-2:0]         THR      = THR_64[W-2:0];
    localparam logic signed [W-1:0]  ONE_Q    = W'(1) << FRAC_BITS;

    // sequencer codes
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_ERR     = 5'd1;
    localparam logic [4:0] S_WRAP    = 5'd2;
    localparam logic [4:0] S_PMUL    = 5'd3;
    localparam logic [4:0] S_PWAIT   = 5'd4;
    localparam logic [4:0] S_KIDIV   = 5'd5;
    localparam logic [4:0] S_KIWAIT  = 5'd6;
    localparam logic [4:0] S_KEMUL   = 5'd7;
    localparam logic [4:0] S_KEWAIT  = 5'd8;
    localparam logic [4:0] S_KDTMUL  = 5'd9;
    localparam logic [4:0] S_KDTWAIT = 5'd10;
    localparam logic [4:0] S_RESET   = 5'd11;
    localparam logic [4:0] S_DY      = 5'd12;
    localparam logic [4:0] S_KDMUL   = 5'd13;
    localparam logic [4:0] S_KDWAIT  = 5'd14;
    localparam logic [4:0] S_DMUL    = 5'd15;
    localparam logic [4:0] S_DWAIT   = 5'd16;
    localparam logic [4:0] S_DDIV    = 5'd17;
    localparam logic [4:0] S_DDWAIT  = 5'd18;
    localparam logic [4:0] S_SUM1    = 5'd19;
    localparam logic [4:0] S_SUM2    = 5'd20;
    localparam logic [4:0] S_CLMIN   = 5'd21;
    localparam logic [4:0] S_CLMAX   = 5'd22;
    localparam logic [4:0] S_DONE    = 5'd23;

    // saturate a wide signed value to the word range
    function automatic logic signed [W-1:0] sat_x(input logic signed [XW-1:0] x);
        logic signed [W-1:0] r;
        if (x > WMAX_X) begin
            r = WMAX_X[W-1:0];
        end else if (x < WMIN_X) begin
            r = WMIN_X[W-1:0];
        end else begin
            r = x[W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [XW-1:0] ext(input logic signed [W-1:0] v);
        return XW'(v);
    endfunction

    // configuration registers
    logic signed [W-1:0] kp_reg, trim_reg, omin_reg, omax_reg;
    logic [W-2:0]        ti_reg, td_reg;
    logic [1:0]          wrap_reg;

    // sequencer and item state
    logic [4:0]          state_reg, state_next;
    logic signed [W-1:0] y_reg, y_next, r_reg, r_next, u_reg, u_next;
    logic [W-2:0]        dt_reg, dt_next;
    logic                en_reg, en_next;
    logic signed [W-1:0] err_reg, err_next, pterm_reg, pterm_next;
    logic signed [W-1:0] tmp_reg, tmp_next, nd_reg, nd_next, o_reg, o_next;
    logic signed [W-1:0] integ_reg, integ_next, last_reg, last_next;
    logic                pend_reg, pend_next;

    // output word
    logic                mvalid_reg, mvalid_next;
    logic signed [W-1:0] mdrive_reg, mdrive_next, minteg_reg, minteg_next;
    logic                mwr_reg, mwr_next;

    // arithmetic units
    logic                mul_start, div_start;
    logic signed [W-1:0] mul_a, mul_b, div_a, div_b, mul_res, div_res;
    pac_unit_status_t    mul_st, div_st;

    logic                ion;
    logic signed [XW-1:0] wr_x, wr_y;
    logic signed [W-1:0] clip_a, clip_b;

    assign ion = (ti_reg > THR);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg   <= '0;
            ti_reg   <= '0;
            td_reg   <= '0;
            trim_reg <= '0;
            omin_reg <= -ONE_Q;
            omax_reg <= ONE_Q;
            wrap_reg <= WRAP_NONE;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_KP:      kp_reg   <= cfg_wdata;
                REG_TI:      ti_reg   <= cfg_wdata[W-2:0];
                REG_TD:      td_reg   <= cfg_wdata[W-2:0];
                REG_TRIM:    trim_reg <= cfg_wdata;
                REG_OUT_MIN: omin_reg <= cfg_wdata;
                REG_OUT_MAX: omax_reg <= cfg_wdata;
                REG_WRAP:    wrap_reg <= cfg_wdata[1:0];
                default:     ;
            endcase
        end
    end

    // operand selection for the shared units
    always_comb begin
        mul_start = 1'b0;
        mul_a     = kp_reg;
        mul_b     = err_reg;
        unique case (state_reg)
            S_PMUL:   mul_start = 1'b1;
            S_KEMUL:  begin mul_start = 1'b1; mul_a = tmp_reg; end
            S_KDTMUL: begin mul_start = 1'b1; mul_a = tmp_reg; mul_b = W'(dt_reg); end
            S_KDMUL:  begin mul_start = 1'b1; mul_b = W'(td_reg); end
            S_DMUL:   begin mul_start = 1'b1; mul_a = tmp_reg; mul_b = nd_reg; end
            default:  ;
        endcase
    end

    always_comb begin
        div_start = (state_reg == S_KIDIV) || (state_reg == S_DDIV);
        div_a     = (state_reg == S_DDIV) ? tmp_reg : kp_reg;
        div_b     = (state_reg == S_DDIV) ? W'(dt_reg) : W'(ti_reg);
    end

    pac_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .op_a(mul_a), .op_b(mul_b), .status(mul_st), .result(mul_res)
    );

    pac_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .op_a(div_a), .op_b(div_b), .status(div_st), .result(div_res)
    );

    // single-turn error wrap
    always_comb begin
        wr_x = ext(err_reg);
        wr_y = wr_x;
        if (wrap_reg == WRAP_DEG) begin
            if (wr_x < -HALF_DEG) wr_x = wr_x + FULL_DEG;
            wr_y = (wr_x > HALF_DEG) ? wr_x - FULL_DEG : wr_x;
        end else if (wrap_reg == WRAP_RAD) begin
            if (wr_x < -PI_X) wr_x = wr_x + TWO_PI_X;
            wr_y = (wr_x > PI_X) ? wr_x - TWO_PI_X : wr_x;
        end
    end

    // present drive clipped: raised to min, then lowered to max
    assign clip_a = (u_reg < omin_reg) ? omin_reg : u_reg;
    assign clip_b = (clip_a > omax_reg) ? omax_reg : clip_a;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next  = state_reg;
        y_next      = y_reg;
        r_next      = r_reg;
        u_next      = u_reg;
        dt_next     = dt_reg;
        en_next     = en_reg;
        err_next    = err_reg;
        pterm_next  = pterm_reg;
        tmp_next    = tmp_reg;
        nd_next     = nd_reg;
        o_next      = o_reg;
        integ_next  = integ_reg;
        last_next   = last_reg;
        pend_next   = pend_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mdrive_next = mdrive_reg;
        minteg_next = minteg_reg;
        mwr_next    = mwr_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    y_next  = s_tdata[W-1:0];
                    r_next  = s_tdata[2*W-1:W];
                    u_next  = s_tdata[3*W-1:2*W];
                    dt_next = s_tdata[4*W-2:3*W];
                    en_next = s_tuser[0];
                    if (s_tuser[1]) pend_next = 1'b1;
                    state_next = S_ERR;
                end
            end
            S_ERR: begin
                err_next   = sat_x(ext(r_reg) - ext(y_reg));
                state_next = S_WRAP;
            end
            S_WRAP: begin
                err_next   = sat_x(wr_y);
                state_next = S_PMUL;
            end
            S_PMUL:  state_next = S_PWAIT;
            S_PWAIT: begin
                if (mul_st.done) begin
                    pterm_next = sat_x(ext(mul_res) + ext(trim_reg));
                    if (ion) begin
                        state_next = S_KIDIV;
                    end else begin
                        integ_next = '0;
                        state_next = S_RESET;
                    end
                end
            end
            // integral gain Kp/Ti, then times error, then times dt
            S_KIDIV:  state_next = S_KIWAIT;
            S_KIWAIT: begin
                if (div_st.done) begin
                    tmp_next   = div_res;
                    state_next = S_KEMUL;
                end
            end
            S_KEMUL:  state_next = S_KEWAIT;
            S_KEWAIT: begin
                if (mul_st.done) begin
                    tmp_next   = mul_res;
                    state_next = S_KDTMUL;
                end
            end
            S_KDTMUL:  state_next = S_KDTWAIT;
            S_KDTWAIT: begin
                if (mul_st.done) begin
                    integ_next = sat_x(ext(integ_reg) + ext(mul_res));
                    state_next = S_RESET;
                end
            end
            // bumpless reset: integral taken back from the present drive
            S_RESET: begin
                if (pend_reg) begin
                    integ_next = ion ? sat_x(ext(clip_b) - ext(pterm_reg)) : '0;
                    pend_next  = 1'b0;
                end
                state_next = S_DY;
            end
            S_DY: begin
                tmp_next   = sat_x(ext(y_reg) - ext(last_reg));
                last_next  = y_reg;
                state_next = S_KDMUL;
            end
            S_KDMUL: begin
                nd_next    = sat_x(-ext(tmp_reg));
                state_next = S_KDWAIT;
            end
            S_KDWAIT: begin
                if (mul_st.done) begin
                    tmp_next   = mul_res;
                    state_next = S_DMUL;
                end
            end
            S_DMUL:  state_next = S_DWAIT;
            S_DWAIT: begin
                if (mul_st.done) begin
                    tmp_next = mul_res;
                    if (dt_reg == '0) begin
                        nd_next    = '0;
                        state_next = S_SUM1;
                    end else begin
                        state_next = S_DDIV;
                    end
                end
            end
            S_DDIV:   state_next = S_DDWAIT;
            S_DDWAIT: begin
                if (div_st.done) begin
                    nd_next    = div_res;
                    state_next = S_SUM1;
                end
            end
            S_SUM1: begin
                tmp_next   = sat_x(ext(pterm_reg) + ext(integ_reg));
                state_next = S_SUM2;
            end
            S_SUM2: begin
                o_next     = sat_x(ext(tmp_reg) + ext(nd_reg));
                state_next = S_CLMIN;
            end
            // clamp with back-calculation of the clipped excess
            S_CLMIN: begin
                if (o_reg < omin_reg) begin
                    if (ion) begin
                        integ_next = sat_x(ext(integ_reg) + (ext(omin_reg) - ext(o_reg)));
                    end
                    o_next = omin_reg;
                end
                state_next = S_CLMAX;
            end
            S_CLMAX: begin
                if (o_reg > omax_reg) begin
                    if (ion) begin
                        integ_next = sat_x(ext(integ_reg) - (ext(o_reg) - ext(omax_reg)));
                    end
                    o_next = omax_reg;
                end
                state_next = S_DONE;
            end
            // hand the word over once the output register is free
            S_DONE: begin
                if (!mvalid_reg || m_tready) begin
                    mvalid_next = 1'b1;
                    mdrive_next = en_reg ? o_reg : '0;
                    mwr_next    = en_reg;
                    minteg_next = integ_reg;
                    if (!en_reg) pend_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            integ_reg  <= '0;
            last_reg   <= '0;
            pend_reg   <= 1'b1;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            integ_reg  <= integ_next;
            last_reg   <= last_next;
            pend_reg   <= pend_next;
            mvalid_reg <= mvalid_next;
        end
        y_reg      <= y_next;
        r_reg      <= r_next;
        u_reg      <= u_next;
        dt_reg     <= dt_next;
        en_reg     <= en_next;
        err_reg    <= err_next;
        pterm_reg  <= pterm_next;
        tmp_reg    <= tmp_next;
        nd_reg     <= nd_next;
        o_reg      <= o_next;
        mdrive_reg <= mdrive_next;
        minteg_reg <= minteg_next;
        mwr_reg    <= mwr_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = OUT_TW'({minteg_reg, mdrive_reg});
    assign m_tuser  = mwr_reg;

    // an accepted word always starts at the error stage
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == S_ERR)
        else $error("accepted word did not start processing");

    // the multiplier is never started while busy
    a_mul_free: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> !mul_st.busy)
        else $error("multiplier started while busy");

    // divider results only arrive where the sequencer waits for them
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_st.done |-> (state_reg == S_KIWAIT || state_reg == S_DDWAIT))
        else $error("divider result arrived unexpectedly");

    // the pending reset is always consumed before the output sum
    a_pend_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SUM1 |-> !pend_reg)
        else $error("reset still pending at output sum");

    // inactive integral stays at zero through the clamps
    a_int_off: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE && !ion |-> integ_reg == '0)
        else $error("integral nonzero while inactive");

endmodule
